@@ rtl/msp_pkg.sv @@
// Shared types, constants and the CRC byte step for the motor speed packet former.
// No dependencies; every other file in rtl/ imports this package.
package msp_pkg;

   localparam int unsigned VALUE_W = 16;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned SPEED_W = 7;
   localparam int unsigned PROD_W = 23;
   localparam int unsigned CRC_W = 16;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [BYTE_W-1:0] DEV_ADDR_RESET = 8'h80;
   localparam logic [BYTE_W-1:0] CMD_FORWARD = 8'h00;
   localparam logic [BYTE_W-1:0] CMD_BACKWARD = 8'h01;
   localparam logic [SPEED_W-1:0] SPEED_SCALE = 7'd127;
   localparam logic [PROD_W-1:0] ROUND_HALF = 23'd16384;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
   localparam logic [CRC_W-1:0] CRC_TOP = 16'h8000;

   typedef struct packed {
      logic axis_present;
      logic signed [VALUE_W-1:0] axis_value;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] packet_byte;
      logic last_byte;
   } rsp_type;

   // One classified command waiting for the serializer.
   typedef struct packed {
      logic backward;
      logic [SPEED_W-1:0] speed;
   } entry_type;

   typedef enum logic [2:0] {
      SEL_IDLE,
      SEL_ADDR,
      SEL_CMD,
      SEL_SPEED,
      SEL_CRC_HI,
      SEL_CRC_LO
   } byte_sel_type;

   // Feed one byte, MSB first, into a CRC16 with polynomial 0x1021.
   function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
         if ((c & CRC_TOP) != '0) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/msp_front.sv @@
// Front end: accepts request items, scales the axis sample to a speed and direction.
// Depends on msp_pkg.
module msp_front (
   input  logic                req_push,
   input  msp_pkg::req_type    req_data,
   input  logic                queue_full,
   output logic                req_full,
   output logic                queue_push,
   output msp_pkg::entry_type  queue_entry
);
   import msp_pkg::*;

   logic                accept;
   logic                negative;
   logic [VALUE_W-1:0]  magnitude;
   logic [PROD_W-1:0]   product;
   logic [PROD_W-1:0]   rounded;
   logic [SPEED_W-1:0]  speed;

   assign req_full = queue_full;
   assign accept = req_push && !queue_full;

   always_comb begin
      negative = req_data.axis_value[VALUE_W-1];
      magnitude = negative ? (~req_data.axis_value + 1'b1) : req_data.axis_value;
      product = PROD_W'(magnitude) * PROD_W'(SPEED_SCALE);
      rounded = product + ROUND_HALF;
      speed = rounded[PROD_W-2 -: SPEED_W];
   end

   // Drop items without an axis; zero speed always goes forward.
   assign queue_push = accept && req_data.axis_present;
   assign queue_entry.backward = negative && (speed != '0);
   assign queue_entry.speed = speed;

endmodule

@@ rtl/msp_queue.sv @@
// Short queue of classified commands between the front end and the serializer.
// Depends on msp_pkg.
module msp_queue #(
   parameter int unsigned DEPTH = msp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  msp_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output msp_pkg::entry_type  head_entry
);
   import msp_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type         mem [DEPTH];
   entry_type         head_ff;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  count_mid;
   logic              do_push;
   logic              do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = head_ff;
   assign do_pop = pop && head_valid;
   assign do_push = push && !full;

   always_comb begin
      count_mid = count_ff - CNT_W'(do_pop);
      count_in = count_mid + CNT_W'(do_push);
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Registered head read; bypass an item that lands in an empty queue.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
      if (do_push && (count_mid == '0)) begin
         head_ff <= push_entry;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

endmodule

@@ rtl/msp_back.sv @@
// Back end: serializes one command into five packet bytes and builds the CRC on the way.
// Depends on msp_pkg.
module msp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [msp_pkg::BYTE_W-1:0] device_address,
   input  logic                head_valid,
   input  msp_pkg::entry_type  head_entry,
   output logic                queue_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output msp_pkg::rsp_type    rsp_data
);
   import msp_pkg::*;

   byte_sel_type      state_ff, state_in;
   entry_type         entry_ff;
   logic [CRC_W-1:0]  crc_ff;
   logic              taken;
   logic              load;

   assign taken = rsp_pop && !rsp_empty;
   assign load = head_valid && ((state_ff == SEL_IDLE) || ((state_ff == SEL_CRC_LO) && taken));
   assign queue_pop = load;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEL_IDLE:   if (head_valid) state_in = SEL_ADDR;
         SEL_ADDR:   if (taken) state_in = SEL_CMD;
         SEL_CMD:    if (taken) state_in = SEL_SPEED;
         SEL_SPEED:  if (taken) state_in = SEL_CRC_HI;
         SEL_CRC_HI: if (taken) state_in = SEL_CRC_LO;
         SEL_CRC_LO: if (taken) state_in = head_valid ? SEL_ADDR : SEL_IDLE;
         default:    state_in = SEL_IDLE;
      endcase
   end

   always_comb begin
      rsp_empty = 1'b0;
      rsp_data.last_byte = 1'b0;
      rsp_data.packet_byte = '0;
      case (state_ff)
         SEL_IDLE:   rsp_empty = 1'b1;
         SEL_ADDR:   rsp_data.packet_byte = device_address;
         SEL_CMD:    rsp_data.packet_byte = entry_ff.backward ? CMD_BACKWARD : CMD_FORWARD;
         SEL_SPEED:  rsp_data.packet_byte = BYTE_W'(entry_ff.speed);
         SEL_CRC_HI: rsp_data.packet_byte = crc_ff[CRC_W-1 -: BYTE_W];
         SEL_CRC_LO: begin
            rsp_data.packet_byte = crc_ff[BYTE_W-1:0];
            rsp_data.last_byte = 1'b1;
         end
         default:    rsp_empty = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Fold each header byte into the CRC as it leaves.
   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= head_entry;
         crc_ff <= '0;
      end else if (taken && ((state_ff == SEL_ADDR) || (state_ff == SEL_CMD) ||
                             (state_ff == SEL_SPEED))) begin
         crc_ff <= crc_feed(crc_ff, rsp_data.packet_byte);
      end
   end

endmodule

@@ rtl/motor_speed_packet_former.sv @@
// Top level of the motor speed packet former: address register, front end, queue, serializer.
// Depends on msp_pkg, msp_front, msp_queue and msp_back.
//
//   channel  ports                                   direction  moves
//   request  req_push, req_full, req_data            in         one axis sample item
//   response rsp_empty, rsp_pop, rsp_data            out        one packet byte item
//   csr      csr_write_enable, csr_write_data        in         device address, no read-back
//
// Each sample with an axis yields five byte items, one per cycle while rsp_pop stays
// high; the byte serializer sets the sustained sample rate.
// The front end takes one sample per cycle until the QUEUE_DEPTH-entry queue fills;
// a sample without an axis is taken as well but emits nothing.
// With the serializer idle, a taken sample is written into the queue, then loaded into
// the serializer, whose address state shows the first byte.
// Reset is synchronous and active high: it empties the queue, idles the serializer and
// sets the device address to 0x80. Low rsp_pop holds the shown byte; req_full backs up
// the request side only once the queue is full.
module motor_speed_packet_former #(
   parameter int unsigned QUEUE_DEPTH = msp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  msp_pkg::req_type              req_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output msp_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_enable,
   input  logic [msp_pkg::BYTE_W-1:0]    csr_write_data
);
   import msp_pkg::*;

   logic [BYTE_W-1:0]  device_address_ff;
   logic               queue_full;
   logic               queue_push;
   entry_type          queue_entry;
   logic               queue_pop;
   logic               head_valid;
   entry_type          head_entry;

   // Hold the device address; the user must write it only while the block is idle (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= DEV_ADDR_RESET;
      end else if (csr_write_enable) begin
         device_address_ff <= csr_write_data;
      end
   end

   // Classify samples: drop those without an axis, scale the rest.
   msp_front u_front (
      .req_push    (req_push),
      .req_data    (req_data),
      .queue_full  (queue_full),
      .req_full    (req_full),
      .queue_push  (queue_push),
      .queue_entry (queue_entry)
   );

   // Decouple the sample side from the byte side.
   msp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (queue_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Advance through the five packet bytes, one per accepted item.
   msp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .device_address (device_address_ff),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .queue_pop      (queue_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_data       (rsp_data)
   );

endmodule

@@ rtl/msp_checker.sv @@
// Port-level checks for the motor speed packet former, bound to its top level.
// Depends on msp_pkg and motor_speed_packet_former.
module msp_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_full,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  msp_pkg::rsp_type  rsp_data
);
   import msp_pkg::*;

   // After reset nothing waits and the request side is open.
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("outputs not idle after reset");

   // A stalled byte holds.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("stalled byte changed");

   // A packet never breaks off before its last byte.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && !rsp_data.last_byte |=> !rsp_empty)
      else $error("packet cut short");

   // The last byte closes a packet: the next byte cannot also be flagged last.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && rsp_data.last_byte |=> rsp_empty || !rsp_data.last_byte)
      else $error("two last bytes in a row");

endmodule

bind motor_speed_packet_former msp_checker u_msp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
